FILE: design/bpsa_pkg.sv
package bpsa_pkg;

    localparam int NUM_BLOCKS = 128;
    localparam int BLK_W      = $clog2(NUM_BLOCKS);
    localparam int CNT_W      = BLK_W + 1;
    localparam int SLOTS      = 3;
    localparam int SIDX_W     = 2;
    localparam int KIND_W     = 3;
    localparam int SLOT_W     = 3;
    localparam int STAT_W     = 3;

    typedef logic [BLK_W-1:0]  t_blk;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [SLOTS-1:0]  t_mask;
    typedef logic [SIDX_W-1:0] t_sidx;

    localparam t_cnt  CHAIN_NULL = t_cnt'(NUM_BLOCKS);
    localparam t_cnt  BLK_LIMIT  = t_cnt'(NUM_BLOCKS);
    localparam t_mask FULL_MASK  = '1;
    localparam logic [KIND_W-1:0] KIND_MAX = 3'd3;

    typedef enum logic [1:0] {
        OP_GET_BLOCK  = 2'd0,
        OP_FREE_BLOCK = 2'd1,
        OP_GET_SLOT   = 2'd2,
        OP_FREE_SLOT  = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK          = 3'd0,
        ST_BAD_KIND    = 3'd1,
        ST_NO_MEMORY   = 3'd2,
        ST_BAD_HANDLE  = 3'd3,
        ST_BAD_SLOT    = 3'd4,
        ST_CHAIN_ERROR = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_TAKE, S_TAKE_RD, S_TAKE_INIT, S_SU_RD, S_SU_CHK,
        S_UL_RD, S_UL_HEAD, S_WALK, S_WALK_CHK, S_UL_FIX, S_UL_CLR, S_PUSH,
        S_RELINK, S_FINISH
    } t_state;

    typedef enum logic [4:0] {
        CMD_NONE, CMD_LOAD, CMD_TGT_HEAD, CMD_POP, CMD_POP_LATCH, CMD_BUMP,
        CMD_INIT, CMD_SU_RD, CMD_GRANT, CMD_SLOT_FREE, CMD_CN_RD_TGT,
        CMD_UL_HEAD, CMD_CN_RD_CUR, CMD_WALK_STEP, CMD_UL_FIX, CMD_UL_CLR,
        CMD_PUSH, CMD_RELINK, CMD_EMIT
    } t_cmd;

    typedef struct packed {
        t_cmd    cmd;
        logic    set_st;
        t_status st;
    } t_ctl;

    typedef struct packed {
        t_op  op;
        logic kind_bad;
        logic stack_nonempty;
        logic bump_avail;
        logic hnd_bad;
        logic stack_full;
        logic head_null;
        logic slot_range_bad;
        logic slot_unused;
        logic no_free;
        logic new_full;
        logic new_empty;
        logic became_partial;
        logic is_head;
        logic walk_ok;
        logic walk_hit;
        logic out_free;
    } t_flags;

endpackage

FILE: design/bpsa_if.sv
interface bpsa_in_if;
    import bpsa_pkg::*;
    logic                valid;
    logic                ready;
    logic [1:0]          operation;
    logic [KIND_W-1:0]   block_kind;
    logic [BLK_W-1:0]    block_handle;
    logic [SLOT_W-1:0]   slot_number;
    modport source (output valid, operation, block_kind, block_handle, slot_number,
                    input ready);
    modport sink   (input valid, operation, block_kind, block_handle, slot_number,
                    output ready);
endinterface

interface bpsa_out_if;
    import bpsa_pkg::*;
    logic                valid;
    logic                ready;
    logic [STAT_W-1:0]   status;
    logic [BLK_W-1:0]    granted_block;
    logic [SIDX_W-1:0]   granted_slot;
    logic                block_returned;
    modport source (output valid, status, granted_block, granted_slot, block_returned,
                    input ready);
    modport sink   (input valid, status, granted_block, granted_slot, block_returned,
                    output ready);
endinterface

FILE: design/bpsa_ctrl.sv
module bpsa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  bpsa_pkg::t_flags i_flags,
    output bpsa_pkg::t_ctl   o_ctl
);
    import bpsa_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state    = r_state;
        o_ctl      = '{cmd: CMD_NONE, set_st: 1'b0, st: ST_OK};
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.cmd = CMD_LOAD;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_FINISH;
                case (i_flags.op)
                    OP_GET_BLOCK: begin
                        if (i_flags.kind_bad) begin
                            o_ctl.set_st = 1'b1;
                            o_ctl.st     = ST_BAD_KIND;
                        end else begin
                            n_state = S_TAKE;
                        end
                    end
                    OP_FREE_BLOCK: begin
                        if (i_flags.hnd_bad || i_flags.stack_full) begin
                            o_ctl.set_st = 1'b1;
                            o_ctl.st     = ST_BAD_HANDLE;
                        end else begin
                            n_state = S_PUSH;
                        end
                    end
                    OP_GET_SLOT: begin
                        if (i_flags.head_null) begin
                            n_state = S_TAKE;
                        end else begin
                            o_ctl.cmd = CMD_TGT_HEAD;
                            n_state   = S_SU_RD;
                        end
                    end
                    OP_FREE_SLOT: begin
                        if (i_flags.hnd_bad) begin
                            o_ctl.set_st = 1'b1;
                            o_ctl.st     = ST_BAD_HANDLE;
                        end else if (i_flags.slot_range_bad) begin
                            o_ctl.set_st = 1'b1;
                            o_ctl.st     = ST_BAD_SLOT;
                        end else begin
                            n_state = S_SU_RD;
                        end
                    end
                    default: n_state = S_FINISH;
                endcase
            end
            S_TAKE: begin
                if (i_flags.stack_nonempty) begin
                    o_ctl.cmd = CMD_POP;
                    n_state   = S_TAKE_RD;
                end else if (i_flags.bump_avail) begin
                    o_ctl.cmd = CMD_BUMP;
                    n_state   = S_TAKE_INIT;
                end else begin
                    o_ctl.set_st = 1'b1;
                    o_ctl.st     = ST_NO_MEMORY;
                    n_state      = S_FINISH;
                end
            end
            S_TAKE_RD: begin
                o_ctl.cmd = CMD_POP_LATCH;
                n_state   = S_TAKE_INIT;
            end
            S_TAKE_INIT: begin
                o_ctl.cmd = CMD_INIT;
                n_state   = (i_flags.op == OP_GET_BLOCK) ? S_FINISH : S_SU_RD;
            end
            S_SU_RD: begin
                o_ctl.cmd = CMD_SU_RD;
                n_state   = S_SU_CHK;
            end
            S_SU_CHK: begin
                n_state = S_FINISH;
                if (i_flags.op == OP_GET_SLOT) begin
                    if (i_flags.no_free) begin
                        o_ctl.set_st = 1'b1;
                        o_ctl.st     = ST_CHAIN_ERROR;
                    end else begin
                        o_ctl.cmd = CMD_GRANT;
                        if (i_flags.new_full) n_state = S_UL_RD;
                    end
                end else if (i_flags.slot_unused) begin
                    o_ctl.set_st = 1'b1;
                    o_ctl.st     = ST_BAD_SLOT;
                end else begin
                    o_ctl.cmd = CMD_SLOT_FREE;
                    if (i_flags.new_empty)           n_state = S_UL_RD;
                    else if (i_flags.became_partial) n_state = S_RELINK;
                end
            end
            S_UL_RD: begin
                o_ctl.cmd = CMD_CN_RD_TGT;
                n_state   = S_UL_HEAD;
            end
            S_UL_HEAD: begin
                o_ctl.cmd = CMD_UL_HEAD;
                n_state   = i_flags.is_head ? S_UL_CLR : S_WALK;
            end
            S_WALK: begin
                if (i_flags.walk_ok) begin
                    o_ctl.cmd = CMD_CN_RD_CUR;
                    n_state   = S_WALK_CHK;
                end else begin
                    // not on the chain
                    o_ctl.set_st = (i_flags.op == OP_FREE_SLOT);
                    o_ctl.st     = ST_CHAIN_ERROR;
                    n_state      = S_FINISH;
                end
            end
            S_WALK_CHK: begin
                if (i_flags.walk_hit) begin
                    n_state = S_UL_FIX;
                end else begin
                    o_ctl.cmd = CMD_WALK_STEP;
                    n_state   = S_WALK;
                end
            end
            S_UL_FIX: begin
                o_ctl.cmd = CMD_UL_FIX;
                n_state   = S_UL_CLR;
            end
            S_UL_CLR: begin
                o_ctl.cmd = CMD_UL_CLR;
                n_state   = S_FINISH;
                if (i_flags.op == OP_FREE_SLOT) begin
                    if (i_flags.stack_full) begin
                        o_ctl.set_st = 1'b1;
                        o_ctl.st     = ST_CHAIN_ERROR;
                    end else begin
                        n_state = S_PUSH;
                    end
                end
            end
            S_PUSH: begin
                o_ctl.cmd = CMD_PUSH;
                n_state   = S_FINISH;
            end
            S_RELINK: begin
                o_ctl.cmd = CMD_RELINK;
                n_state   = S_FINISH;
            end
            S_FINISH: begin
                if (i_flags.out_free) begin
                    o_ctl.cmd = CMD_EMIT;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: design/bpsa_dp.sv
module bpsa_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bpsa_pkg::t_ctl              i_ctl,
    output bpsa_pkg::t_flags            o_flags,
    input  logic [1:0]                  i_operation,
    input  logic [bpsa_pkg::KIND_W-1:0] i_block_kind,
    input  bpsa_pkg::t_blk              i_block_handle,
    input  logic [bpsa_pkg::SLOT_W-1:0] i_slot_number,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [bpsa_pkg::STAT_W-1:0] o_status,
    output bpsa_pkg::t_blk              o_granted_block,
    output bpsa_pkg::t_sidx             o_granted_slot,
    output logic                        o_block_returned
);
    import bpsa_pkg::*;

    t_blk  m_stack [NUM_BLOCKS];
    t_mask m_su    [NUM_BLOCKS];
    t_cnt  m_cn    [NUM_BLOCKS];

    t_op               r_op;
    logic [KIND_W-1:0] r_kind;
    t_blk              r_tgt;
    logic [SLOT_W-1:0] r_slot;
    t_cnt              r_fc, r_bump, r_head, r_nxt, r_cur, r_steps;
    t_blk              r_stack_rd;
    t_mask             r_su_rd;
    t_cnt              r_cn_rd;
    t_status           r_st;
    t_blk              r_gblk;
    t_sidx             r_gslot;
    logic              r_ret;
    logic              r_o_valid;
    t_status           r_o_st;
    t_blk              r_o_gblk;
    t_sidx             r_o_gslot;
    logic              r_o_ret;

    t_blk  fc_dec;
    t_mask slot_bit, set_mask, clr_mask;
    t_sidx low_idx;
    logic  low_none;
    int    zeros;

    assign fc_dec   = BLK_W'(r_fc - t_cnt'(1));
    assign slot_bit = t_mask'(1) << r_slot;
    assign clr_mask = r_su_rd & ~slot_bit;

    // lowest free slot of the block just read
    always_comb begin
        low_idx  = '0;
        low_none = 1'b1;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_su_rd[i]) begin
                low_idx  = SIDX_W'(i);
                low_none = 1'b0;
            end
        end
        set_mask = r_su_rd | (t_mask'(1) << low_idx);
        zeros    = 0;
        for (int i = 0; i < SLOTS; i++) begin
            if (!clr_mask[i]) zeros = zeros + 1;
        end
    end

    always_comb begin
        o_flags.op             = r_op;
        o_flags.kind_bad       = r_kind > KIND_MAX;
        o_flags.stack_nonempty = r_fc != '0;
        o_flags.bump_avail     = r_bump < BLK_LIMIT;
        o_flags.hnd_bad        = {1'b0, r_tgt} >= r_bump;
        o_flags.stack_full     = r_fc >= BLK_LIMIT;
        o_flags.head_null      = r_head >= BLK_LIMIT;
        o_flags.slot_range_bad = r_slot >= SLOT_W'(SLOTS);
        o_flags.slot_unused    = (r_su_rd & slot_bit) == '0;
        o_flags.no_free        = low_none;
        o_flags.new_full       = set_mask == FULL_MASK;
        o_flags.new_empty      = clr_mask == '0;
        o_flags.became_partial = zeros == 1;
        o_flags.is_head        = r_head == {1'b0, r_tgt};
        o_flags.walk_ok        = (r_steps < BLK_LIMIT) && (r_cur < BLK_LIMIT);
        o_flags.walk_hit       = r_cn_rd == {1'b0, r_tgt};
        o_flags.out_free       = !r_o_valid || i_out_ready;
    end

    // free stack
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmd == CMD_PUSH) m_stack[r_fc[BLK_W-1:0]] <= r_tgt;
        if (i_ctl.cmd == CMD_POP)  r_stack_rd <= m_stack[fc_dec];
    end

    // slot masks
    always_ff @(posedge i_clk) begin
        case (i_ctl.cmd)
            CMD_INIT:      m_su[r_tgt] <= '0;
            CMD_SU_RD:     r_su_rd     <= m_su[r_tgt];
            CMD_GRANT:     m_su[r_tgt] <= set_mask;
            CMD_SLOT_FREE: m_su[r_tgt] <= clr_mask;
            default: ;
        endcase
    end

    // chain links
    always_ff @(posedge i_clk) begin
        case (i_ctl.cmd)
            CMD_INIT:      m_cn[r_tgt] <= CHAIN_NULL;
            CMD_CN_RD_TGT: r_cn_rd     <= m_cn[r_tgt];
            CMD_CN_RD_CUR: r_cn_rd     <= m_cn[r_cur[BLK_W-1:0]];
            CMD_UL_FIX:    m_cn[r_cur[BLK_W-1:0]] <= r_nxt;
            CMD_UL_CLR:    m_cn[r_tgt] <= CHAIN_NULL;
            CMD_RELINK:    m_cn[r_tgt] <= r_head;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc      <= '0;
            r_bump    <= '0;
            r_head    <= CHAIN_NULL;
            r_o_valid <= 1'b0;
        end else begin
            if (i_ctl.set_st) r_st <= i_ctl.st;
            case (i_ctl.cmd)
                CMD_LOAD: begin
                    r_op    <= t_op'(i_operation);
                    r_kind  <= i_block_kind;
                    r_tgt   <= i_block_handle;
                    r_slot  <= i_slot_number;
                    r_st    <= ST_OK;
                    r_gblk  <= '0;
                    r_gslot <= '0;
                    r_ret   <= 1'b0;
                end
                CMD_TGT_HEAD:  r_tgt  <= r_head[BLK_W-1:0];
                CMD_POP:       r_fc   <= r_fc - t_cnt'(1);
                CMD_POP_LATCH: r_tgt  <= r_stack_rd;
                CMD_BUMP: begin
                    r_tgt  <= r_bump[BLK_W-1:0];
                    r_bump <= r_bump + t_cnt'(1);
                end
                CMD_INIT: begin
                    if (r_op == OP_GET_BLOCK) r_gblk <= r_tgt;
                    else                      r_head <= {1'b0, r_tgt};
                end
                CMD_GRANT: begin
                    r_gblk  <= r_tgt;
                    r_gslot <= low_idx;
                end
                CMD_UL_HEAD: begin
                    r_nxt   <= r_cn_rd;
                    r_cur   <= r_head;
                    r_steps <= '0;
                    if (r_head == {1'b0, r_tgt}) r_head <= r_cn_rd;
                end
                CMD_WALK_STEP: begin
                    r_cur   <= r_cn_rd;
                    r_steps <= r_steps + t_cnt'(1);
                end
                CMD_PUSH: begin
                    r_fc  <= r_fc + t_cnt'(1);
                    r_ret <= (r_op == OP_FREE_SLOT);
                end
                CMD_RELINK: r_head <= {1'b0, r_tgt};
                default: ;
            endcase
            // output register: hold until the transfer completes
            if (i_ctl.cmd == CMD_EMIT) begin
                r_o_valid <= 1'b1;
                r_o_st    <= r_st;
                r_o_gblk  <= r_gblk;
                r_o_gslot <= r_gslot;
                r_o_ret   <= r_ret;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_status         = r_o_st;
    assign o_granted_block  = r_o_gblk;
    assign o_granted_slot   = r_o_gslot;
    assign o_block_returned = r_o_ret;

endmodule

FILE: design/block_pool_with_slot_suballocator_core.sv
// Block pool with descriptor-slot suballocator.
// i_req carries one request (operation, block_kind, block_handle, slot_number);
// o_rsp carries one result per request (status, granted_block, granted_slot,
// block_returned). Both channels transfer when valid and ready are high.
// One request is worked at a time by a sequencer over single-port tables for
// the free stack, slot masks and chain links; each table read is registered.
// When a block must be unlinked from behind the chain head, the sequencer walks
// the chain, reading and checking one link at a time (up to 128 links), and
// then fixes the link that pointed at the block.
// The result sits in an output register, so a new request is accepted while
// the previous result waits; if the receiver stalls with a result still held,
// the next result waits in the sequencer and no further request is accepted.
// Reset (synchronous, active low) empties the pool: no free blocks, no block
// ever handed out, empty partial chain. No clearing pass is needed.
module block_pool_with_slot_suballocator_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bpsa_in_if.sink    i_req,
    bpsa_out_if.source o_rsp
);
    import bpsa_pkg::*;

    t_ctl   ctl;
    t_flags flags;

    bpsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_flags    (flags),
        .o_ctl      (ctl)
    );

    bpsa_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (ctl),
        .o_flags          (flags),
        .i_operation      (i_req.operation),
        .i_block_kind     (i_req.block_kind),
        .i_block_handle   (i_req.block_handle),
        .i_slot_number    (i_req.slot_number),
        .i_out_ready      (o_rsp.ready),
        .o_out_valid      (o_rsp.valid),
        .o_status         (o_rsp.status),
        .o_granted_block  (o_rsp.granted_block),
        .o_granted_slot   (o_rsp.granted_slot),
        .o_block_returned (o_rsp.block_returned)
    );

endmodule

FILE: design/bpsa_chk.sv
module bpsa_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [bpsa_pkg::STAT_W-1:0] i_status,
    input bpsa_pkg::t_blk              i_granted_block,
    input bpsa_pkg::t_sidx             i_granted_slot,
    input logic                        i_block_returned
);
    import bpsa_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_granted_block) && $stable(i_granted_slot)
            && $stable(i_block_returned))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while another is in work");

    a_return_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_block_returned |-> i_status == ST_OK)
        else $error("block returned with error status");

    a_err_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_OK |-> i_granted_block == '0 && i_granted_slot == '0)
        else $error("grant reported with error status");

endmodule

bind block_pool_with_slot_suballocator_core bpsa_chk u_bpsa_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_req.valid),
    .i_in_ready       (i_req.ready),
    .i_out_valid      (o_rsp.valid),
    .i_out_ready      (o_rsp.ready),
    .i_status         (o_rsp.status),
    .i_granted_block  (o_rsp.granted_block),
    .i_granted_slot   (o_rsp.granted_slot),
    .i_block_returned (o_rsp.block_returned)
);
